/* src/nested_index_counter_top_assert.svh */
// Assertion helpers for the nested index counter.
// Both macros sample on i_clk and stay quiet while i_rst_n is low.
`ifndef NESTED_INDEX_COUNTER_TOP_ASSERT_SVH
`define NESTED_INDEX_COUNTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NIC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/nic_pkg.sv */
`default_nettype none

package nic_pkg;

    // Defaults for the top level parameters.
    localparam int MAX_DIMS_DEF   = 4;
    localparam int INDEX_BITS_DEF = 12;

    // Fixed field widths.
    localparam int FUNC_W     = 2;
    localparam int IDX_W      = 12;
    localparam int SIZE_W     = 12;
    localparam int DIMC_W     = 3;
    localparam int WIDE_W     = 48;
    localparam int NUM_SIZE   = 4;
    localparam int SIZE_SEL_W = 2;
    localparam int STEP_W     = 3;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Item function codes.
    localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_LINEAR  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_DIM_COUNT = 3'd0;
    localparam logic [2:0] REG_SIZE_DIM0 = 3'd1;
    localparam logic [2:0] REG_SIZE_DIM1 = 3'd2;
    localparam logic [2:0] REG_SIZE_DIM2 = 3'd3;
    localparam logic [2:0] REG_SIZE_DIM3 = 3'd4;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        OP_START,
        OP_NOP,
        OP_POS,
        OP_TOT,
        OP_LIN,
        OP_EMIT
    } t_op;

    // Branch condition of a control word.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_ITEM,
        C_NO_DIMS,
        C_LAST_K,
        C_OUT_FREE
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_START = 3'd0;
    localparam t_step S_CHECK = 3'd1;
    localparam t_step S_POS   = 3'd2;
    localparam t_step S_TOT   = 3'd3;
    localparam t_step S_LIN   = 3'd4;
    localparam t_step S_EMIT  = 3'd5;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step go_true;
        t_step go_false;
    } t_ctrl;

    typedef struct packed {
        logic item;
        logic no_dims;
        logic last_k;
        logic out_free;
    } t_flags;

    // The microprogram. Each dimension in use costs a position MAC,
    // a size product and a given-tuple MAC on the shared multiplier.
    function automatic t_ctrl f_program(input t_step s);
        t_ctrl w;
        case (s)
            S_START: w = '{op: OP_START, cond: C_ITEM,     go_true: S_CHECK, go_false: S_START};
            S_CHECK: w = '{op: OP_NOP,   cond: C_NO_DIMS,  go_true: S_EMIT,  go_false: S_POS};
            S_POS:   w = '{op: OP_POS,   cond: C_ALWAYS,   go_true: S_TOT,   go_false: S_TOT};
            S_TOT:   w = '{op: OP_TOT,   cond: C_ALWAYS,   go_true: S_LIN,   go_false: S_LIN};
            S_LIN:   w = '{op: OP_LIN,   cond: C_LAST_K,   go_true: S_EMIT,  go_false: S_POS};
            S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_FREE, go_true: S_START, go_false: S_EMIT};
            default: w = '{op: OP_NOP,   cond: C_ALWAYS,   go_true: S_START, go_false: S_START};
        endcase
        return w;
    endfunction

    // A size register holding zero counts as one.
    function automatic logic [SIZE_W-1:0] f_size_eff(input logic [SIZE_W-1:0] s);
        return (s == '0) ? SIZE_W'(1) : s;
    endfunction

endpackage

`default_nettype wire

/* src/nic_seq.sv */
`default_nettype none

module nic_seq
    import nic_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_flags i_flags,
    output t_ctrl  o_ctrl
);

    t_step r_step;
    t_step n_step;
    logic  w_take;

    assign o_ctrl = f_program(r_step);

    always_comb begin
        case (o_ctrl.cond)
            C_ALWAYS:   w_take = 1'b1;
            C_ITEM:     w_take = i_flags.item;
            C_NO_DIMS:  w_take = i_flags.no_dims;
            C_LAST_K:   w_take = i_flags.last_k;
            C_OUT_FREE: w_take = i_flags.out_free;
            default:    w_take = 1'b1;
        endcase
        n_step = w_take ? o_ctrl.go_true : o_ctrl.go_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_START;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

/* src/nested_index_counter_top.sv */
// Channel  | Handshake                        | Word
// ---------+----------------------------------+---------------------------------------
// input    | i_in_valid / o_in_stall          | i_func, i_given_idx0..3
// output   | o_out_valid / i_out_stall        | o_advanced, o_cur_idx0..3,
//          |                                  | o_linear_offset, o_bad_index,
//          |                                  | o_total_count
// config   | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// An item runs through the single 48x12 multiplier, which performs a position
// MAC, a size product and a given-tuple MAC for every dimension in use; with no
// dimensions in use those steps are skipped.
// Reset is synchronous and active low; it restores dim_count = 1, every size
// to 1, the tuple to all ones and clears the exhausted bit.
// A stalled output word holds in its register; the next input word is taken
// while it waits, and the sequencer only parks at the end of that item.
`default_nettype none
`include "nested_index_counter_top_assert.svh"

module nested_index_counter_top
    import nic_pkg::*;
#(
    parameter int MAX_DIMS   = MAX_DIMS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,

    // Input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [IDX_W-1:0]      i_given_idx0,
    input  logic [IDX_W-1:0]      i_given_idx1,
    input  logic [IDX_W-1:0]      i_given_idx2,
    input  logic [IDX_W-1:0]      i_given_idx3,

    // Output channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_advanced,
    output logic [IDX_W-1:0]      o_cur_idx0,
    output logic [IDX_W-1:0]      o_cur_idx1,
    output logic [IDX_W-1:0]      o_cur_idx2,
    output logic [IDX_W-1:0]      o_cur_idx3,
    output logic [WIDE_W-1:0]     o_linear_offset,
    output logic                  o_bad_index,
    output logic [WIDE_W-1:0]     o_total_count
);

    // Width of the dimension counter and of size/index compares.
    localparam int KW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CW = (INDEX_BITS > SIZE_W) ? INDEX_BITS : SIZE_W;

    // Configuration registers.
    logic [DIMC_W-1:0]     r_dim_count;
    logic [SIZE_W-1:0]     r_size [NUM_SIZE];

    // Tuple state.
    logic [INDEX_BITS-1:0] r_pos [MAX_DIMS];
    logic [INDEX_BITS-1:0] n_pos [MAX_DIMS];
    logic                  r_exhausted;
    logic                  n_exhausted;
    logic                  n_adv;

    // Per-item working registers.
    logic [FUNC_W-1:0]     r_func;
    logic [INDEX_BITS-1:0] r_given [MAX_DIMS];
    logic                  r_adv;
    logic [KW-1:0]         r_k;
    logic [WIDE_W-1:0]     r_pos_acc;
    logic [WIDE_W-1:0]     r_tot;
    logic [WIDE_W-1:0]     r_lin;
    logic                  r_bad;

    // Output register.
    logic                  r_out_valid;
    logic                  r_out_adv;
    logic [IDX_W-1:0]      r_out_cur [NUM_SIZE];
    logic [WIDE_W-1:0]     r_out_lin;
    logic                  r_out_bad;
    logic [WIDE_W-1:0]     r_out_tot;

    // Sequencer interface.
    t_ctrl                 w_ctrl;
    t_flags                w_flags;

    logic                  w_cfg_wr;
    logic [2:0]            w_cfg_idx;
    logic [DIMC_W-1:0]     w_n;
    logic [SIZE_W-1:0]     w_size_eff [NUM_SIZE];
    logic [SIZE_SEL_W-1:0] w_ksel;
    logic [IDX_W-1:0]      w_given_in [NUM_SIZE];
    logic [IDX_W-1:0]      w_pos_wide [NUM_SIZE];
    logic [INDEX_BITS-1:0] w_odo_pos [MAX_DIMS];
    logic                  w_odo_found;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_emit_load;
    logic [WIDE_W-1:0]     w_mul_a;
    logic [SIZE_W-1:0]     w_mul_b;
    logic [WIDE_W-1:0]     w_addend;
    logic [WIDE_W+SIZE_W-1:0] w_prod;
    logic [WIDE_W-1:0]     w_mac;
    logic [INDEX_BITS-1:0] w_given_k;
    logic                  w_bad_k;

    // ------------------------------------------------------------------
    // Configuration port. Writes land on the access cycle; pready is tied
    // high so every access completes at once.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = paddr[CFG_ADDR_W-1:2];

    always_comb begin
        case (w_cfg_idx)
            REG_DIM_COUNT: prdata = CFG_DATA_W'(r_dim_count);
            REG_SIZE_DIM0: prdata = CFG_DATA_W'(r_size[0]);
            REG_SIZE_DIM1: prdata = CFG_DATA_W'(r_size[1]);
            REG_SIZE_DIM2: prdata = CFG_DATA_W'(r_size[2]);
            REG_SIZE_DIM3: prdata = CFG_DATA_W'(r_size[3]);
            default:       prdata = '0;
        endcase
    end

    // A dimension count beyond what the block holds is clipped.
    assign w_n = (r_dim_count > DIMC_W'(MAX_DIMS)) ? DIMC_W'(MAX_DIMS) : r_dim_count;

    always_comb begin
        for (int d = 0; d < NUM_SIZE; d++) begin
            w_size_eff[d] = f_size_eff(r_size[d]);
        end
    end

    assign w_given_in[0] = i_given_idx0;
    assign w_given_in[1] = i_given_idx1;
    assign w_given_in[2] = i_given_idx2;
    assign w_given_in[3] = i_given_idx3;

    // Current tuple on the fixed output width; slots the block does not
    // hold read as zero.
    for (genvar g = 0; g < NUM_SIZE; g++) begin : g_pos_wide
        if (g < MAX_DIMS) begin : g_held
            assign w_pos_wide[g] = IDX_W'(r_pos[g]);
        end else begin : g_absent
            assign w_pos_wide[g] = '0;
        end
    end

    // ------------------------------------------------------------------
    // Odometer step. Walking from the fastest dimension down, the first
    // index still below its size is bumped and every faster one returns to
    // one. An index at or above its size counts as at its end. When every
    // dimension is at its end, the slowest index stays where it is.
    // ------------------------------------------------------------------
    always_comb begin
        w_odo_found = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++) begin
            w_odo_pos[d] = r_pos[d];
        end
        for (int d = MAX_DIMS - 1; d >= 0; d--) begin
            if ((DIMC_W'(d) < w_n) && !w_odo_found) begin
                if (CW'(r_pos[d]) < CW'(w_size_eff[d])) begin
                    w_odo_pos[d] = r_pos[d] + INDEX_BITS'(1);
                    w_odo_found  = 1'b1;
                end else if (d != 0) begin
                    w_odo_pos[d] = INDEX_BITS'(1);
                end
            end
        end
    end

    // Tuple update happens in the cycle the word is taken.
    assign w_accept = i_in_valid && (w_ctrl.op == OP_START);

    always_comb begin
        for (int d = 0; d < MAX_DIMS; d++) begin
            n_pos[d] = r_pos[d];
        end
        n_exhausted = r_exhausted;
        n_adv       = 1'b0;
        if (w_accept && (w_n != '0)) begin
            case (i_func)
                FUNC_RESTART: begin
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        n_pos[d] = INDEX_BITS'(1);
                    end
                    n_exhausted = 1'b0;
                    n_adv       = 1'b1;
                end
                FUNC_ADVANCE: begin
                    if (!r_exhausted) begin
                        for (int d = 0; d < MAX_DIMS; d++) begin
                            n_pos[d] = w_odo_pos[d];
                        end
                        n_adv       = w_odo_found;
                        n_exhausted = !w_odo_found;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiply-accumulate. The control word picks which running
    // value is scaled by the size of dimension k and what is added to it.
    // ------------------------------------------------------------------
    assign w_ksel    = SIZE_SEL_W'(r_k);
    assign w_mul_b   = w_size_eff[w_ksel];
    assign w_given_k = r_given[r_k];

    always_comb begin
        case (w_ctrl.op)
            OP_POS: begin
                w_mul_a  = r_pos_acc;
                w_addend = WIDE_W'(r_pos[r_k]) - WIDE_W'(1);
            end
            OP_TOT: begin
                w_mul_a  = r_tot;
                w_addend = '0;
            end
            OP_LIN: begin
                w_mul_a  = r_lin;
                w_addend = WIDE_W'(w_given_k) - WIDE_W'(1);
            end
            default: begin
                w_mul_a  = r_lin;
                w_addend = '0;
            end
        endcase
    end

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_mac   = w_prod[WIDE_W-1:0] + w_addend;
    assign w_bad_k = (w_given_k == '0) || (CW'(w_given_k) > CW'(w_mul_b));

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit_load = (w_ctrl.op == OP_EMIT) && w_out_free;

    assign w_flags.item     = w_accept;
    assign w_flags.no_dims  = (w_n == '0);
    assign w_flags.last_k   = (DIMC_W'(r_k) == (w_n - DIMC_W'(1)));
    assign w_flags.out_free = w_out_free;

    nic_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    assign o_in_stall = (w_ctrl.op != OP_START);

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_count <= DIMC_W'(1);
            for (int d = 0; d < NUM_SIZE; d++) begin
                r_size[d] <= SIZE_W'(1);
            end
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_pos[d] <= INDEX_BITS'(1);
            end
            r_exhausted <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (w_cfg_idx)
                    REG_DIM_COUNT: r_dim_count <= pwdata[DIMC_W-1:0];
                    REG_SIZE_DIM0: r_size[0]   <= pwdata[SIZE_W-1:0];
                    REG_SIZE_DIM1: r_size[1]   <= pwdata[SIZE_W-1:0];
                    REG_SIZE_DIM2: r_size[2]   <= pwdata[SIZE_W-1:0];
                    REG_SIZE_DIM3: r_size[3]   <= pwdata[SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end

            for (int d = 0; d < MAX_DIMS; d++) begin
                r_pos[d] <= n_pos[d];
            end
            r_exhausted <= n_exhausted;

            // A new word seeds the running values: the total starts at one
            // only when some dimension is in use.
            if (w_accept) begin
                r_func <= i_func;
                for (int d = 0; d < MAX_DIMS; d++) begin
                    r_given[d] <= INDEX_BITS'(w_given_in[d]);
                end
                r_adv     <= n_adv;
                r_k       <= '0;
                r_pos_acc <= '0;
                r_tot     <= (w_n == '0) ? WIDE_W'(0) : WIDE_W'(1);
                r_lin     <= '0;
                r_bad     <= 1'b0;
            end

            case (w_ctrl.op)
                OP_POS: r_pos_acc <= w_mac;
                OP_TOT: r_tot     <= w_mac;
                OP_LIN: begin
                    r_lin <= w_mac;
                    if ((r_func == FUNC_LINEAR) && w_bad_k) begin
                        r_bad <= 1'b1;
                    end
                    r_k <= r_k + KW'(1);
                end
                default: begin
                end
            endcase

            // The finished word waits here, so the sequencer is free to
            // take the next input word.
            if (w_emit_load) begin
                r_out_valid <= 1'b1;
                r_out_adv   <= r_adv;
                for (int d = 0; d < NUM_SIZE; d++) begin
                    r_out_cur[d] <= (DIMC_W'(d) < w_n) ? w_pos_wide[d] : '0;
                end
                if (r_func == FUNC_LINEAR) begin
                    r_out_lin <= r_bad ? '0 : r_lin;
                end else begin
                    r_out_lin <= r_pos_acc;
                end
                r_out_bad <= r_bad;
                r_out_tot <= r_tot;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_advanced      = r_out_adv;
    assign o_cur_idx0      = r_out_cur[0];
    assign o_cur_idx1      = r_out_cur[1];
    assign o_cur_idx2      = r_out_cur[2];
    assign o_cur_idx3      = r_out_cur[3];
    assign o_linear_offset = r_out_lin;
    assign o_bad_index     = r_out_bad;
    assign o_total_count   = r_out_tot;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The dimension counter stays inside the dimensions in use while the
    // multiplier loop runs.
    `NIC_ASSERT_SAME(a_k_in_range, (w_ctrl.op == OP_POS) || (w_ctrl.op == OP_TOT) || (w_ctrl.op == OP_LIN), DIMC_W'(r_k) < w_n, "dimension counter ran past the dimensions in use")

    // A flagged tuple always reports a zero offset.
    `NIC_ASSERT_SAME(a_bad_gives_zero, o_out_valid && o_bad_index, o_linear_offset == '0, "bad index reported with a nonzero offset")

    // The output word only appears from the emit step.
    `NIC_ASSERT_SAME(a_out_from_emit, $rose(o_out_valid), $past(w_ctrl.op == OP_EMIT), "output word raised outside the emit step")

    // A word handed to a free output register sends the sequencer back to
    // take the next input word.
    `NIC_ASSERT_NEXT(a_emit_returns, (w_ctrl.op == OP_EMIT) && !r_out_valid, w_ctrl.op == OP_START, "sequencer did not return after emitting")

endmodule

`default_nettype wire
